/* hdl/wrs_pkg.sv */
// Package for the windowed regression slope core.
// Payload structs, request/status codes and sequencer states; no dependencies.
package wrs_pkg;

  localparam int RATE_W   = 24;
  localparam int UTIL_W   = 24;
  localparam int COUNT_W  = 7;
  localparam int SLOPE_W  = 32;
  localparam int WSIZE_W  = 7;
  localparam int ACC_W    = 64;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SLOPE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_RESERVED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [RATE_W-1:0]        rate;
    logic signed [UTIL_W-1:0] utility;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic                      full_res;
    logic signed [SLOPE_W-1:0] slope;
    logic                      slope_valid;
    logic [1:0]                status;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDMEM,
    ST_MLOAD,
    ST_MRUN,
    ST_UPD,
    ST_SETUP,
    ST_DLOAD,
    ST_DRUN,
    ST_FIN
  } state_t;

endpackage

/* hdl/windowed_regression_slope_core.sv */
// Windowed least-squares slope core: FIFO window of (rate, utility) pairs, running sums,
// bit-serial multiplier and restoring divider. Depends on wrs_pkg.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | wrs_pkg::in_t
//   out_    | output    | out_valid / out_ready | wrs_pkg::out_t
//   cfg_    | input     | cfg_valid / cfg_ready | window_size, 7 bits
//
// One transaction at a time. An append runs two serial multiplies over the SX_W-bit multiplier
// (SX_W = 24 + log2 MAX_INTERVALS, 30 by default); a remove reads the store first. A slope query
// runs four multiplies then a one-bit-per-cycle divide of the 62 + SLOPE_FRAC_BITS dividend bits,
// skipped when the denominator is not positive. Rejected and unused requests go straight to
// the result step. The result register holds while out_ready is low; the sequencer then waits
// at its last step. Reset is synchronous; the stores need no clearing.
module windowed_regression_slope_core #(
  parameter int MAX_INTERVALS   = 64,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wrs_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wrs_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrs_pkg::WSIZE_W-1:0]     cfg_data
);
  import wrs_pkg::*;

  localparam int AW     = $clog2(MAX_INTERVALS);
  localparam int CW     = $clog2(MAX_INTERVALS + 1);
  localparam int SX_W   = RATE_W + AW;
  localparam int SY_W   = UTIL_W + AW;
  localparam int SXY_W  = RATE_W + UTIL_W + AW;
  localparam int SXX_W  = 2 * RATE_W + AW;
  localparam int DVD_W  = 62 + SLOPE_FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // storage
  logic [RATE_W-1:0]        rate_store    [MAX_INTERVALS];
  logic signed [UTIL_W-1:0] utility_store [MAX_INTERVALS];
  logic [RATE_W-1:0]        rd_rate_r;
  logic signed [UTIL_W-1:0] rd_util_r;
  logic                     wr_en;
  logic [AW-1:0]            wr_pos;

  state_t                   state_r, state_nxt;
  logic [1:0]               req_r, req_nxt;
  logic [AW-1:0]            oldest_r, oldest_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [SX_W-1:0]          sx_r, sx_nxt;
  logic signed [SY_W-1:0]   sy_r, sy_nxt;
  logic signed [SXY_W-1:0]  sxy_r, sxy_nxt;
  logic [SXX_W-1:0]         sxx_r, sxx_nxt;
  logic [WSIZE_W-1:0]       wsize_r, wsize_nxt;

  logic [RATE_W-1:0]        x_r, x_nxt;
  logic signed [UTIL_W-1:0] y_r, y_nxt;

  logic [1:0]               midx_r, midx_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [SX_W-1:0]          mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_r [4];
  logic signed [ACC_W-1:0]  prod_nxt [4];

  logic signed [ACC_W-1:0]  num_r, num_nxt;
  logic [ACC_W-1:0]         den_r, den_nxt;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [ACC_W-1:0]         rem_r, rem_nxt;
  logic [SLOPE_W-1:0]       quo_r, quo_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     neg_r, neg_nxt;

  logic [SLOPE_W-1:0]       slope_r, slope_nxt;
  logic                     valid_r, valid_nxt;
  logic [1:0]               status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_r, out_nxt;

  // scratch
  logic [AW:0]              pos_sum;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-1:0]         rem_sh;
  logic                     qbit;
  logic                     big;
  logic                     last_mul;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rate_store[wr_pos]    <= in_data.rate;
      utility_store[wr_pos] <= in_data.utility;
    end
    rd_rate_r <= rate_store[oldest_r];
    rd_util_r <= utility_store[oldest_r];
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sxy_nxt       = sxy_r;
    sxx_nxt       = sxx_r;
    wsize_nxt     = wsize_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    midx_nxt      = midx_r;
    step_nxt      = step_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    neg_nxt       = neg_r;
    slope_nxt     = slope_r;
    valid_nxt     = valid_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;

    pos_sum  = (AW+1)'(oldest_r) + (AW+1)'(count_r);
    if (pos_sum >= (AW+1)'(MAX_INTERVALS)) begin
      pos_sum = pos_sum - (AW+1)'(MAX_INTERVALS);
    end
    wr_pos   = pos_sum[AW-1:0];
    mag      = num_r[ACC_W-1] ? ACC_W'(-num_r) : ACC_W'(num_r);
    rem_sh   = {rem_r[ACC_W-2:0], dvd_r[DVD_W-1]};
    qbit     = (rem_sh >= den_r);
    big      = ovf_r | quo_r[SLOPE_W-1];
    last_mul = (req_r == REQ_SLOPE) ? (midx_r == 2'd3) : (midx_r == 2'd1);

    if (cfg_valid) begin
      wsize_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data.req_type;
          slope_nxt  = '0;
          valid_nxt  = 1'b0;
          status_nxt = STS_OK;
          midx_nxt   = 2'd0;
          case (in_data.req_type)
            REQ_APPEND: begin
              if (count_r == CW'(MAX_INTERVALS)) begin
                status_nxt = STS_FULL;
                state_nxt  = ST_FIN;
              end else begin
                wr_en     = 1'b1;
                x_nxt     = in_data.rate;
                y_nxt     = in_data.utility;
                state_nxt = ST_MLOAD;
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
                state_nxt  = ST_FIN;
              end else begin
                state_nxt = ST_RDMEM;
              end
            end
            REQ_SLOPE: state_nxt = ST_MLOAD;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RDMEM: begin
        x_nxt     = rd_rate_r;
        y_nxt     = rd_util_r;
        state_nxt = ST_MLOAD;
      end
      ST_MLOAD: begin
        acc_nxt  = '0;
        step_nxt = '0;
        if (req_r == REQ_SLOPE) begin
          case (midx_r)
            2'd0: begin mcand_nxt = ACC_W'(sxy_r);   mplier_nxt = SX_W'(count_r); end
            2'd1: begin mcand_nxt = ACC_W'(sy_r);    mplier_nxt = sx_r;           end
            2'd2: begin mcand_nxt = $signed(ACC_W'(sxx_r)); mplier_nxt = SX_W'(count_r); end
            default: begin mcand_nxt = $signed(ACC_W'(sx_r)); mplier_nxt = sx_r;  end
          endcase
        end else if (midx_r == 2'd0) begin
          mcand_nxt  = ACC_W'(y_r);
          mplier_nxt = SX_W'(x_r);
        end else begin
          mcand_nxt  = $signed(ACC_W'(x_r));
          mplier_nxt = SX_W'(x_r);
        end
        state_nxt = ST_MRUN;
      end
      ST_MRUN: begin
        acc_nxt    = acc_r + (mplier_r[0] ? mcand_r : '0);
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(SX_W - 1)) begin
          prod_nxt[midx_r] = acc_nxt;
          midx_nxt         = midx_r + 1'b1;
          if (!last_mul) begin
            state_nxt = ST_MLOAD;
          end else if (req_r == REQ_SLOPE) begin
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (req_r == REQ_APPEND) begin
          sx_nxt    = sx_r + SX_W'(x_r);
          sy_nxt    = sy_r + SY_W'(y_r);
          sxy_nxt   = sxy_r + SXY_W'(prod_r[0]);
          sxx_nxt   = sxx_r + SXX_W'(prod_r[1]);
          count_nxt = count_r + 1'b1;
        end else begin
          sx_nxt     = sx_r - SX_W'(x_r);
          sy_nxt     = sy_r - SY_W'(y_r);
          sxy_nxt    = sxy_r - SXY_W'(prod_r[0]);
          sxx_nxt    = sxx_r - SXX_W'(prod_r[1]);
          count_nxt  = count_r - 1'b1;
          oldest_nxt = (oldest_r == AW'(MAX_INTERVALS - 1)) ? '0 : oldest_r + 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_SETUP: begin
        num_nxt   = prod_r[0] - prod_r[1];
        den_nxt   = ACC_W'(prod_r[2] - prod_r[3]);
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        // only a strictly positive denominator yields a slope
        if (den_r[ACC_W-1] || den_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          neg_nxt   = num_r[ACC_W-1];
          dvd_nxt   = DVD_W'(mag) << SLOPE_FRAC_BITS;
          rem_nxt   = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
          step_nxt  = '0;
          state_nxt = ST_DRUN;
        end
      end
      ST_DRUN: begin
        rem_nxt  = qbit ? rem_sh - den_r : rem_sh;
        quo_nxt  = {quo_r[SLOPE_W-2:0], qbit};
        ovf_nxt  = ovf_r | quo_r[SLOPE_W-1];
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (req_r == REQ_SLOPE && !(den_r[ACC_W-1] || den_r == '0)) begin
          valid_nxt = 1'b1;
          if (neg_r) begin
            slope_nxt = big ? {1'b1, {(SLOPE_W-1){1'b0}}} : SLOPE_W'(-quo_r);
          end else begin
            slope_nxt = big ? {1'b0, {(SLOPE_W-1){1'b1}}} : quo_r;
          end
        end
        if (!out_valid_r || out_ready) begin
          out_nxt.count       = COUNT_W'(count_r);
          out_nxt.full_res    = (COUNT_W'(count_r) >= wsize_r);
          out_nxt.slope       = slope_nxt;
          out_nxt.slope_valid = valid_nxt;
          out_nxt.status      = status_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      sxx_r       <= '0;
      wsize_r     <= WSIZE_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxy_r       <= sxy_nxt;
      sxx_r       <= sxx_nxt;
      wsize_r     <= wsize_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    midx_r   <= midx_nxt;
    step_r   <= step_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    ovf_r    <= ovf_nxt;
    neg_r    <= neg_nxt;
    slope_r  <= slope_nxt;
    valid_r  <= valid_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* hdl/wrs_checker.sv */
// Port-level assertions for the windowed regression slope core, with its bind.
// Depends on wrs_pkg and windowed_regression_slope_core.
module wrs_checker #(
  parameter int MAX_INTERVALS = 64
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input wrs_pkg::out_t out_data
);
  import wrs_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_slope_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.slope_valid |-> out_data.slope == '0)
    else $error("slope nonzero without slope_valid");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STS_FULL |-> out_data.count == 7'(MAX_INTERVALS))
    else $error("append rejected below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STS_EMPTY |-> out_data.count == '0 &&
    !out_data.slope_valid)
    else $error("remove rejected on nonempty store");

endmodule

bind windowed_regression_slope_core wrs_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_wrs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/wrs_checker.sv */
// Scoreboard for the windowed regression slope core: predicts each result from accepted
// transactions and compares against the out_ channel. Depends on wrs_pkg.
`timescale 1ns / 100ps
module wrs_scoreboard (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  wrs_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  wrs_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [6:0]    cfg_data,
  output int            fail_count,
  output int            pending_results,
  output int            slopes_valid_seen
);
  import wrs_pkg::*;

  localparam int DEPTH  = 64;
  localparam int QDEPTH = 8;

  logic [23:0]        pair_rate [DEPTH];
  logic signed [23:0] pair_util [DEPTH];
  int unsigned        head_pos;
  int unsigned        n_pairs;
  longint             sx, sy, sxy, sxx;
  logic [6:0]         win_size;
  out_t               exp_buf [QDEPTH];
  int                 exp_wr, exp_rd, exp_count;

  assign pending_results = exp_count;

  function automatic logic [31:0] slope_divide(longint num, longint den);
    logic    neg;
    logic [127:0] mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << 16) / den;
    if (neg) return (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic out_t predict_result(in_t t);
    out_t    r;
    longint  x, y, num, den;
    int unsigned p;
    r = '0;
    case (req_t'(t.req_type))
      REQ_APPEND: begin
        if (n_pairs >= DEPTH) r.status = STS_FULL;
        else begin
          p = (head_pos + n_pairs) % DEPTH;
          pair_rate[p] = t.rate;
          pair_util[p] = t.utility;
          x = t.rate;
          y = t.utility;
          n_pairs++;
          sx += x; sy += y; sxy += x * y; sxx += x * x;
        end
      end
      REQ_REMOVE: begin
        if (n_pairs == 0) r.status = STS_EMPTY;
        else begin
          x = pair_rate[head_pos];
          y = pair_util[head_pos];
          sx -= x; sy -= y; sxy -= x * y; sxx -= x * x;
          head_pos = (head_pos + 1) % DEPTH;
          n_pairs--;
        end
      end
      REQ_SLOPE: begin
        num = longint'(n_pairs) * sxy - sx * sy;
        den = longint'(n_pairs) * sxx - sx * sx;
        if (den > 0) begin
          r.slope = slope_divide(num, den);
          r.slope_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = n_pairs[6:0];
    r.full_res = n_pairs >= win_size;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      head_pos = 0; n_pairs = 0;
      sx = 0; sy = 0; sxy = 0; sxx = 0;
      win_size = 7'd4;
      exp_wr = 0; exp_rd = 0; exp_count = 0;
      fail_count = 0;
      slopes_valid_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) win_size = cfg_data;
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected result transaction %p", out_data);
        end else begin
          e = exp_buf[exp_rd];
          exp_rd = (exp_rd + 1) % QDEPTH;
          exp_count = exp_count - 1;
          if (out_data.slope_valid) slopes_valid_seen = slopes_valid_seen + 1;
          if (out_data.count !== e.count || out_data.full_res !== e.full_res ||
              out_data.slope !== e.slope || out_data.slope_valid !== e.slope_valid ||
              out_data.status !== e.status) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (exp_count == QDEPTH) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("too many transactions in flight");
        end else begin
          exp_buf[exp_wr] = predict_result(in_data);
          exp_wr = (exp_wr + 1) % QDEPTH;
          exp_count = exp_count + 1;
        end
      end
    end
  end

endmodule

/* sim/tb_windowed_regression_slope_core.sv */
// Testbench top for windowed_regression_slope_core: directed and random request streams
// with random idling on both channels. Depends on wrs_pkg, the core and wrs_scoreboard.
`timescale 1ns / 100ps
module tb_windowed_regression_slope_core;
  import wrs_pkg::*;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0, in_ready;
  in_t        in_data = '0;
  logic       out_valid, out_ready = 0;
  out_t       out_data;
  logic       cfg_valid = 0, cfg_ready;
  logic [6:0] cfg_data = '0;
  int         fail_count, pending_results, slopes_valid_seen;
  int         send_idle_pct = 9, recv_idle_pct = 80;
  longint     cycle_count = 0;
  int         n_sent = 0;

  always #4 clk = ~clk;

  windowed_regression_slope_core dut (.*);

  wrs_scoreboard chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // valid stays high after acceptance until the next idle cycle or a drain
  task automatic send_item(req_t req, logic [23:0] rate, logic [23:0] util);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, rate: rate, utility: util};
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_window(logic [6:0] w);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly appends of small windows, slopes often; sometimes fills to capacity
  task automatic random_item(int fill_bias);
    int k;
    logic [23:0] r;
    k = $urandom_range(99);
    case ($urandom_range(3))
      0: r = 24'($urandom);
      1: r = 24'($urandom_range(16));
      2: r = 24'(24'h800000 + $urandom_range(7));
      default: r = 24'($urandom_range(4000));
    endcase
    if (k < 45 + fill_bias) send_item(REQ_APPEND, r, 24'($urandom));
    else if (k < 70) send_item(REQ_REMOVE, 0, 0);
    else if (k < 97) send_item(REQ_SLOPE, 24'($urandom), 24'($urandom));
    else send_item(REQ_NONE, 24'($urandom), 24'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty cases, extremes, saturation, capacity
    send_item(REQ_REMOVE, 0, 0);
    send_item(REQ_SLOPE, 0, 0);
    send_item(REQ_NONE, 24'hFFFFFF, 24'hFFFFFF);
    send_item(REQ_APPEND, 24'hFFFFFF, 24'h7FFFFF);
    send_item(REQ_SLOPE, 0, 0);
    send_item(REQ_APPEND, 24'hFFFFFF, 24'h800000);
    send_item(REQ_SLOPE, 0, 0);
    send_item(REQ_APPEND, 0, 24'h800000);
    send_item(REQ_APPEND, 1, 24'h7FFFFF);
    send_item(REQ_SLOPE, 0, 0);
    send_item(REQ_REMOVE, 0, 0);
    send_item(REQ_REMOVE, 0, 0);
    send_item(REQ_SLOPE, 0, 0);
    send_item(REQ_APPEND, 0, 24'h800000);
    send_item(REQ_SLOPE, 0, 0);
    for (int i = 0; i < 65; i++) send_item(REQ_APPEND, 24'($urandom), 24'($urandom));
    send_item(REQ_SLOPE, 0, 0);
    write_window(7'd64);
    send_item(REQ_NONE, 0, 0);
    for (int i = 0; i < 66; i++) send_item(REQ_REMOVE, 0, 0);

    send_idle_pct = 9; recv_idle_pct = 80;
    write_window(7'd0);
    for (int i = 0; i < 250; i++) random_item(0);
    write_window(7'd1);
    for (int i = 0; i < 100; i++) random_item(10);
    drain_results();  // sender holds off until all results are back
    send_idle_pct = 80; recv_idle_pct = 9;
    write_window(7'd127);
    for (int i = 0; i < 150; i++) random_item(20);
    write_window(7'($urandom_range(2, 63)));
    for (int i = 0; i < 100; i++) random_item(0);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_window(7'd4);
    for (int i = 0; i < 150; i++) random_item(5);
    drain_results();

    $display("sent %0d requests over seven window settings; %0d valid slopes checked",
             n_sent, slopes_valid_seen);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
hdl/wrs_pkg.sv
hdl/windowed_regression_slope_core.sv
hdl/wrs_checker.sv
sim/wrs_checker.sv
sim/tb_windowed_regression_slope_core.sv
